FILE: hdl/joint_reference_profile_generator_top_macros.svh
// Assertion macros shared by the profile generator RTL
`ifndef JOINT_REFERENCE_PROFILE_GENERATOR_TOP_MACROS_SVH
`define JOINT_REFERENCE_PROFILE_GENERATOR_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define JRPG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define JRPG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/jrpg_pkg.sv
// Types, codes and helpers for the joint reference profile generator
package jrpg_pkg;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QAW    = 2;

    localparam logic [2:0] MODE_OFF   = 3'd0;
    localparam logic [2:0] MODE_POS   = 3'd1;
    localparam logic [2:0] MODE_VEL   = 3'd2;
    localparam logic [2:0] MODE_HOME  = 3'd3;
    localparam logic [2:0] MODE_RESET = 3'd4;

    localparam logic [2:0] OUT_ADVANCED  = 3'd0;
    localparam logic [2:0] OUT_HOMED     = 3'd1;
    localparam logic [2:0] OUT_SKIPPED   = 3'd2;
    localparam logic [2:0] OUT_FROZEN    = 3'd3;
    localparam logic [2:0] OUT_RESETDONE = 3'd4;
    localparam logic [2:0] OUT_NONE      = 3'd5;

    localparam logic CFG_DT_MAX     = 1'b0;
    localparam logic CFG_ERR_FACTOR = 1'b1;

    localparam logic [24:0] DT_MAX_RESET     = 25'd1677722;
    localparam logic [7:0]  ERR_FACTOR_RESET = 8'd10;

    typedef struct packed {
        logic [5:0]         joint;
        logic [2:0]         mode;
        logic signed [31:0] target_pos;
        logic signed [31:0] target_vel;
        logic signed [31:0] accel_limit;
        logic signed [31:0] max_speed;
        logic signed [31:0] pos_min;
        logic signed [31:0] pos_max;
        logic signed [31:0] measured_pos;
        logic signed [31:0] dt;
        logic               ref_wait;
    } req_t;

    typedef struct packed {
        logic [5:0]         joint_out;
        logic signed [31:0] ref_pos;
        logic signed [31:0] velocity;
        logic               faulted;
        logic [2:0]         outcome;
    } res_t;

    // request plus front-end classification
    typedef struct packed {
        req_t req;
        logic skip;
        logic oor;
    } qitem_t;

    // per-joint stored state
    typedef struct packed {
        logic signed [31:0] ref_pos;
        logic signed [31:0] vel;
        logic               fault;
        logic               rdone;
    } entry_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_PREP,
        ST_DECIDE,
        ST_SQRT,
        ST_SLEW,
        ST_STEP,
        ST_ROUND,
        ST_DONE
    } bk_state_t;

    function automatic logic [31:0] mag32(input logic signed [31:0] x);
        mag32 = x[31] ? 32'(-x) : 32'(x);
    endfunction

endpackage

FILE: hdl/jrpg_front.sv
// Request queue and classification (skip, joint out of range)
module jrpg_front
    import jrpg_pkg::*;
#(
    parameter int JOINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req_data,
    input  logic [24:0] dt_max,
    output logic        q_valid,
    output qitem_t      q_item,
    input  logic        q_pop
);

    qitem_t           fifo_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg;
    logic [QAW-1:0]   rd_ptr_reg;
    logic [QAW:0]     cnt_reg;
    logic             push;
    logic             pop;
    qitem_t           new_item;

    assign req_stall = (cnt_reg == (QAW+1)'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (cnt_reg != '0);
    assign pop       = q_pop && q_valid;
    assign q_item    = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        new_item.req  = req_data;
        // processed only for 0 < dt < dt_max and no hold
        new_item.skip = !((req_data.dt > 32'sd0) &&
                          ($unsigned(req_data.dt) < {7'b0, dt_max})) || req_data.ref_wait;
        new_item.oor  = ({3'b000, req_data.joint} >= 9'(JOINTS));
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= new_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

FILE: hdl/jrpg_back.sv
// Execution sequencer: joint state memory, slew, square-root braking, clamp, freeze
module jrpg_back
    import jrpg_pkg::*;
#(
    parameter int JOINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [24:0] dt_max,
    input  logic [7:0]  error_factor,
    input  logic        q_valid,
    input  qitem_t      q_item,
    output logic        q_pop,
    output logic        bk_valid,
    output res_t        bk_res,
    input  logic        bk_ready
);

    localparam int AW = (JOINTS > 1) ? $clog2(JOINTS) : 1;

    bk_state_t state_reg, state_next;

    entry_t            mem [JOINTS];
    logic [JOINTS-1:0] vld_reg;
    entry_t            rd_reg;
    logic              rd_vld_reg;

    qitem_t             cur_reg;
    entry_t             st_reg;
    logic [56:0]        m_thr_reg;
    logic [56:0]        m_acc_reg;
    logic [32:0]        err_reg;
    logic signed [32:0] dr_reg;
    logic [40:0]        thr_reg;
    logic [32:0]        a_reg;
    logic [63:0]        sq_x_reg;
    logic [63:0]        sq_r_reg;
    logic [63:0]        sq_bit_reg;
    logic               ok_reg;
    logic signed [31:0] v_reg;
    logic [56:0]        vprod_reg;
    logic signed [32:0] vdt_reg;

    logic [AW-1:0]      rd_addr;
    logic [AW-1:0]      wr_addr;
    logic               wr_en;
    entry_t             load_e;
    logic signed [32:0] err_diff;
    logic [32:0]        dr_mag;
    logic [64:0]        sq_prod;
    logic [63:0]        sq_sum;
    logic               sq_ge;
    logic               ok_now;

    logic signed [39:0] v0w, aw, tvw, tvm, adrw, v0m, dv_raw, dv, vs;
    logic               dr_pos, dr_neg;
    logic [32:0]        vrnd;
    logic signed [34:0] ref0w, stepw, nref, pminw, pmaxw, clampw;
    logic [32:0]        vdt_mag;
    logic               same_dir;
    entry_t             new_e;
    logic [2:0]         outcome;

    assign rd_addr = AW'(q_item.req.joint);
    assign wr_addr = AW'(cur_reg.req.joint);
    assign q_pop   = (state_reg == ST_IDLE) && q_valid;
    assign bk_valid = (state_reg == ST_DONE);
    assign wr_en   = bk_valid && bk_ready && !cur_reg.oor;

    // ---------------- load stage helpers
    always_comb
    begin
        load_e   = rd_vld_reg ? rd_reg : '0;
        err_diff = {load_e.ref_pos[31], load_e.ref_pos}
                 - {cur_reg.req.measured_pos[31], cur_reg.req.measured_pos};
    end

    assign dr_mag  = dr_reg[32] ? 33'(-dr_reg) : 33'(dr_reg);
    // 2*|accel|*|dr| wraps at 64 bits
    assign sq_prod = 65'(mag32(cur_reg.req.accel_limit)) * 65'(dr_mag);
    assign sq_sum  = sq_r_reg + sq_bit_reg;
    assign sq_ge   = (sq_x_reg >= sq_sum);
    assign ok_now  = ({8'b0, err_reg} <= thr_reg) && !st_reg.fault;

    // ---------------- velocity slew
    always_comb
    begin
        v0w    = 40'(st_reg.vel);
        aw     = {7'b0, a_reg};
        tvw    = 40'(cur_reg.req.target_vel);
        tvm    = {8'b0, mag32(cur_reg.req.target_vel)};
        adrw   = {7'b0, sq_r_reg[32:0]};
        v0m    = v0w[39] ? -v0w : v0w;
        dr_neg = dr_reg[32];
        dr_pos = !dr_reg[32] && (dr_reg != '0);
        if (cur_reg.req.mode == MODE_VEL)
        begin
            dv_raw = tvw - v0w;
        end
        else if (v0m >= adrw)
        begin
            dv_raw = (dr_pos ? adrw : (dr_neg ? -adrw : 40'sd0)) - v0w;
        end
        else
        begin
            dv_raw = (dr_pos ? tvm : (dr_neg ? -tvm : 40'sd0)) - v0w;
        end
        if (dv_raw > aw)
        begin
            dv = aw;
        end
        else if (dv_raw < -aw)
        begin
            dv = -aw;
        end
        else
        begin
            dv = dv_raw;
        end
        vs = v0w + dv;
    end

    assign vrnd = 33'((vprod_reg + 57'(24'h800000)) >> 24);

    // ---------------- reference update and outcome
    always_comb
    begin
        ref0w   = 35'(st_reg.ref_pos);
        pminw   = 35'(cur_reg.req.pos_min);
        pmaxw   = 35'(cur_reg.req.pos_max);
        vdt_mag = vdt_reg[32] ? 33'(-vdt_reg) : 33'(vdt_reg);
        same_dir = (v_reg == 32'sd0) ||
                   (!v_reg[31] == (!dr_reg[32] && (dr_reg != '0)));
        if (cur_reg.req.mode == MODE_VEL)
        begin
            stepw = 35'(vdt_reg);
        end
        else if (dr_mag > vdt_mag)
        begin
            stepw = same_dir ? 35'(vdt_reg) : -35'(vdt_reg);
        end
        else
        begin
            stepw = 35'(dr_reg);
        end
        nref = ref0w + stepw;
        if (nref < pminw)
        begin
            clampw = pminw;
        end
        else if (nref > pmaxw)
        begin
            clampw = pmaxw;
        end
        else
        begin
            clampw = nref;
        end

        new_e   = st_reg;
        outcome = OUT_NONE;
        if (cur_reg.skip)
        begin
            outcome = OUT_SKIPPED;
        end
        else if (ok_reg)
        begin
            if (cur_reg.req.mode != MODE_OFF && cur_reg.req.mode != MODE_RESET)
            begin
                case (cur_reg.req.mode)
                    MODE_VEL, MODE_POS:
                    begin
                        new_e.ref_pos = clampw[31:0];
                        new_e.vel     = v_reg;
                        outcome       = OUT_ADVANCED;
                    end
                    MODE_HOME:
                    begin
                        new_e.ref_pos = '0;
                        new_e.vel     = '0;
                        outcome       = OUT_HOMED;
                    end
                    default:
                    begin
                        outcome = OUT_NONE;
                    end
                endcase
                new_e.rdone = 1'b0;
            end
        end
        else if (!st_reg.fault && cur_reg.req.mode != MODE_HOME)
        begin
            new_e.vel     = '0;
            new_e.ref_pos = cur_reg.req.measured_pos;
            new_e.fault   = 1'b1;
            outcome       = OUT_FROZEN;
        end
        else if (cur_reg.req.mode == MODE_RESET && !st_reg.rdone)
        begin
            new_e.vel   = '0;
            new_e.fault = 1'b0;
            new_e.rdone = 1'b1;
            outcome     = OUT_RESETDONE;
        end

        bk_res.joint_out = cur_reg.req.joint;
        if (cur_reg.oor)
        begin
            bk_res.ref_pos  = '0;
            bk_res.velocity = '0;
            bk_res.faulted  = 1'b0;
            bk_res.outcome  = OUT_NONE;
        end
        else
        begin
            bk_res.ref_pos  = new_e.ref_pos;
            bk_res.velocity = new_e.vel;
            bk_res.faulted  = new_e.fault;
            bk_res.outcome  = outcome;
        end
    end

    // ---------------- sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                state_next = (cur_reg.skip || cur_reg.oor) ? ST_DONE : ST_PREP;
            end
            ST_PREP:
            begin
                state_next = ST_DECIDE;
            end
            ST_DECIDE:
            begin
                if (ok_now && cur_reg.req.mode == MODE_POS)
                begin
                    state_next = ST_SQRT;
                end
                else if (ok_now && cur_reg.req.mode == MODE_VEL)
                begin
                    state_next = ST_SLEW;
                end
                else
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SQRT:
            begin
                if (sq_bit_reg[0])
                begin
                    state_next = ST_SLEW;
                end
            end
            ST_SLEW:
            begin
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                state_next = ST_ROUND;
            end
            ST_ROUND:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (bk_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
        end
    end

    // state memory
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= new_e;
        end
        if (q_pop)
        begin
            rd_reg     <= mem[rd_addr];
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    cur_reg <= q_item;
                end
            end
            ST_LOAD:
            begin
                st_reg    <= load_e;
                m_thr_reg <= 57'(mag32(cur_reg.req.max_speed)) * 57'(dt_max);
                m_acc_reg <= 57'(mag32(cur_reg.req.accel_limit)) * 57'(cur_reg.req.dt[24:0]);
                err_reg   <= err_diff[32] ? 33'(-err_diff) : 33'(err_diff);
                dr_reg    <= {cur_reg.req.target_pos[31], cur_reg.req.target_pos}
                           - {load_e.ref_pos[31], load_e.ref_pos};
            end
            ST_PREP:
            begin
                thr_reg    <= 41'(33'((m_thr_reg + 57'(24'h800000)) >> 24)) * 41'(error_factor);
                a_reg      <= 33'((m_acc_reg + 57'(24'h800000)) >> 24);
                sq_x_reg   <= {sq_prod[62:0], 1'b0};
                sq_r_reg   <= '0;
                sq_bit_reg <= 64'h4000_0000_0000_0000;
            end
            ST_DECIDE:
            begin
                ok_reg <= ok_now;
            end
            ST_SQRT:
            begin
                if (sq_ge)
                begin
                    sq_x_reg <= sq_x_reg - sq_sum;
                    sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                end
                else
                begin
                    sq_r_reg <= sq_r_reg >> 1;
                end
                sq_bit_reg <= sq_bit_reg >> 2;
            end
            ST_SLEW:
            begin
                if (vs > 40'sh007FFFFFFF)
                begin
                    v_reg <= 32'sh7FFFFFFF;
                end
                else if (vs < -40'sh0080000000)
                begin
                    v_reg <= 32'sh80000000;
                end
                else
                begin
                    v_reg <= vs[31:0];
                end
            end
            ST_STEP:
            begin
                vprod_reg <= 57'(mag32(v_reg)) * 57'(cur_reg.req.dt[24:0]);
            end
            ST_ROUND:
            begin
                vdt_reg <= v_reg[31] ? 33'(-vrnd) : 33'(vrnd);
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: hdl/joint_reference_profile_generator_top.sv
// Joint reference profile generator top level: config registers, queue, sequencer, output register.
// Each request is one joint tick; a 4-entry queue accepts requests while the sequencer works on
// earlier ones, and a result register lets the next request proceed while a result waits. The
// sequencer ends skipped and out-of-range ticks at once, home, off, reset, freeze and invalid ticks
// at the decision; velocity ticks slew, step and round, and position ticks run a 64-bit square root
// first, one bit pair per cycle. Joint state is one memory, read once per tick and written once per
// in-range tick; per-entry valid bits make it read zero after reset, so no clearing pass is needed.
`include "joint_reference_profile_generator_top_macros.svh"

module joint_reference_profile_generator_top
    import jrpg_pkg::*;
#(
    parameter int JOINTS = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        req_valid,
    output logic        req_stall,
    input  req_t        req_data,
    output logic        res_valid,
    input  logic        res_stall,
    output res_t        res_data,
    input  logic        cfg_write,
    input  logic        cfg_index,
    input  logic [24:0] cfg_data
);

    logic [24:0] dt_max_reg;
    logic [7:0]  error_factor_reg;
    logic        res_valid_reg;
    res_t        res_data_reg;

    logic        q_valid;
    qitem_t      q_item;
    logic        q_pop;
    logic        bk_valid;
    res_t        bk_res;
    logic        bk_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dt_max_reg       <= DT_MAX_RESET;
            error_factor_reg <= ERR_FACTOR_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DT_MAX:     dt_max_reg       <= cfg_data;
                CFG_ERR_FACTOR: error_factor_reg <= cfg_data[7:0];
                default:        dt_max_reg       <= dt_max_reg;
            endcase
        end
    end

    jrpg_front #(.JOINTS(JOINTS)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_data  (req_data),
        .dt_max    (dt_max_reg),
        .q_valid   (q_valid),
        .q_item    (q_item),
        .q_pop     (q_pop)
    );

    jrpg_back #(.JOINTS(JOINTS)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .dt_max       (dt_max_reg),
        .error_factor (error_factor_reg),
        .q_valid      (q_valid),
        .q_item       (q_item),
        .q_pop        (q_pop),
        .bk_valid     (bk_valid),
        .bk_res       (bk_res),
        .bk_ready     (bk_ready)
    );

    assign bk_ready = !res_valid_reg || !res_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (bk_valid && bk_ready)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (!res_stall)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bk_valid && bk_ready)
        begin
            res_data_reg <= bk_res;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    `JRPG_ASSERT_NEXT(a_bk_hold, bk_valid && !bk_ready, bk_valid, "sequencer dropped a result")
    `JRPG_ASSERT_NOW(a_oor_zero, res_valid && ({3'b000, res_data.joint_out} >= 9'(JOINTS)), res_data.ref_pos == '0 && res_data.velocity == '0 && !res_data.faulted && res_data.outcome == OUT_NONE, "out-of-range joint gave state")
    `JRPG_ASSERT_NOW(a_adv_healthy, res_valid && (res_data.outcome == OUT_ADVANCED || res_data.outcome == OUT_HOMED), !res_data.faulted, "faulted joint advanced")
    `JRPG_ASSERT_NOW(a_frozen_flag, res_valid && res_data.outcome == OUT_FROZEN, res_data.faulted && res_data.velocity == '0, "freeze without fault flag")

endmodule
